### sv/checked_integer_alu_defines.svh
// Assertion helpers for the ALU back end module
`ifndef CHECKED_INTEGER_ALU_DEFINES_SVH
`define CHECKED_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define CIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define CIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cia_pkg.sv
package cia_pkg;

  // operation codes; the last code is a no-operation
  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_MOD  = 4'd4,
    OP_NEG  = 4'd5,
    OP_EQ   = 4'd6,
    OP_LT   = 4'd7,
    OP_AND  = 4'd8,
    OP_OR   = 4'd9,
    OP_XOR  = 4'd10,
    OP_NOT  = 4'd11,
    OP_SHL  = 4'd12,
    OP_SHR  = 4'd13,
    OP_BYTE = 4'd14,
    OP_NOP  = 4'd15
  } op_e;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_ADD_OVF  = 4'd1;
  localparam logic [3:0] ERR_SUB_OVF  = 4'd2;
  localparam logic [3:0] ERR_MUL_OVF  = 4'd3;
  localparam logic [3:0] ERR_DIV_ZERO = 4'd4;
  localparam logic [3:0] ERR_DIV_OVF  = 4'd5;
  localparam logic [3:0] ERR_MOD_ZERO = 4'd6;
  localparam logic [3:0] ERR_NEG_OVF  = 4'd7;
  localparam logic [3:0] ERR_SHIFT    = 4'd8;
  localparam logic [3:0] ERR_BYTE     = 4'd9;
  localparam logic [3:0] ERR_MAX      = ERR_BYTE;

  localparam int unsigned BYTE_MAX = 255;
  localparam int unsigned CLS_W    = 6;

  // operand classification made at the front
  typedef struct packed {
    logic a_min;      // a is the most negative value
    logic b_zero;
    logic min_m1;     // most negative value over minus one
    logic shift_bad;  // shift amount outside 0..width-1
    logic byte_bad;   // a outside 0..255
    logic sign_diff;  // operand signs differ
  } cls_t;

  // control carried alongside each item in the back pipeline
  typedef struct packed {
    logic [3:0] err;
    logic       is_mul;
    logic       is_div;
    logic       is_mod;
    logic       neg;
    logic       a_neg;
  } rec_t;

endpackage

### sv/cia_if.sv
// request channel: operation and two operands
interface cia_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink   (input valid, cmd, operand_a, operand_b, output ready);
endinterface

// response channel: result and error code
interface cia_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic [3:0]  error_code;
  modport source (output valid, result, error_code, input ready);
  modport sink   (input valid, result, error_code, output ready);
endinterface

### sv/cia_fifo.sv
module cia_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] rdata_o
);

  logic [W-1:0] mem_q [2];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // store entry
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

### sv/cia_front.sv
module cia_front import cia_pkg::*; #(
  parameter int unsigned DW = 64
) (
  cia_req_if.sink          req,
  input  logic             full_i,
  output logic             push_o,
  output logic [3:0]       cmd_o,
  output cls_t             cls_o,
  output logic [DW-1:0]    a_o,
  output logic [DW-1:0]    b_o
);

  localparam logic [DW-1:0] MinV = {1'b1, {(DW-1){1'b0}}};

  logic [DW-1:0] a, b;

  assign a = req.operand_a[DW-1:0];
  assign b = req.operand_b[DW-1:0];

  assign req.ready = ~full_i;
  assign push_o    = req.valid & ~full_i;
  assign cmd_o     = req.cmd;
  assign a_o       = a;
  assign b_o       = b;

  // classify operands
  always_comb begin
    cls_o.a_min     = (a == MinV);
    cls_o.b_zero    = ~|b;
    cls_o.min_m1    = (a == MinV) && (&b);
    cls_o.shift_bad = b[DW-1] || (b > DW'(DW - 1));
    cls_o.byte_bad  = a[DW-1] || (64'(a) > 64'(BYTE_MAX));
    cls_o.sign_diff = a[DW-1] ^ b[DW-1];
  end

endmodule

### sv/cia_back.sv
`include "checked_integer_alu_defines.svh"

module cia_back import cia_pkg::*; #(
  parameter int unsigned DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          h_valid_i,
  input  logic [3:0]    h_cmd_i,
  input  cls_t          h_cls_i,
  input  logic [DW-1:0] h_a_i,
  input  logic [DW-1:0] h_b_i,
  output logic          pop_o,
  cia_rsp_if.source     rsp
);

  localparam int unsigned SW = $clog2(DW);
  localparam int unsigned L  = (DW + 1) / 2;
  localparam int unsigned H  = DW - L;
  localparam int unsigned N  = DW + 1;
  localparam logic [DW-1:0] MinV = {1'b1, {(DW-1){1'b0}}};

  logic          adv;
  logic [DW-1:0] res0, sum, dif, mag_a, mag_b;
  rec_t          rec0;

  logic          vld_q [N];
  logic [DW-1:0] rem_q [N];
  logic [DW-1:0] dvd_q [N];
  logic [DW-1:0] dvs_q [N];
  logic [DW-1:0] res_q [N];
  rec_t          rec_q [N];
  logic [DW-1:0] rem_d [N];
  logic [DW-1:0] dvd_d [N];
  logic [DW-1:0] res_d [N];
  rec_t          rec_d [N];

  logic [2*L-1:0]  pll_q;
  logic [L+H-1:0]  plh_q, phl_q;
  logic [2*H-1:0]  phh_q;
  logic [2*DW-1:0] prod_q;
  logic [DW-1:0]   mul_res, lim, fin;
  logic            mul_ovf;

  logic          out_valid_q;
  logic [63:0]   out_res_q;
  logic [3:0]    out_err_q;

  // whole pipeline moves when the output register is free or taken
  assign adv   = ~out_valid_q | rsp.ready;
  assign pop_o = adv & h_valid_i;

  assign sum   = h_a_i + h_b_i;
  assign dif   = h_a_i - h_b_i;
  assign mag_a = h_a_i[DW-1] ? (~h_a_i + 1'b1) : h_a_i;
  assign mag_b = h_b_i[DW-1] ? (~h_b_i + 1'b1) : h_b_i;

  // execute combinational operations and flag traps other than multiply overflow
  always_comb begin
    res0        = '0;
    rec0        = '0;
    rec0.neg    = h_cls_i.sign_diff;
    rec0.a_neg  = h_a_i[DW-1];
    case (op_e'(h_cmd_i))
      OP_ADD: begin
        if (((h_a_i ^ sum) & (h_b_i ^ sum)) >> (DW - 1) != '0) rec0.err = ERR_ADD_OVF;
        else res0 = sum;
      end
      OP_SUB: begin
        if (((h_a_i ^ h_b_i) & (h_a_i ^ dif)) >> (DW - 1) != '0) rec0.err = ERR_SUB_OVF;
        else res0 = dif;
      end
      OP_MUL: rec0.is_mul = 1'b1;
      OP_DIV: begin
        if (h_cls_i.b_zero)      rec0.err = ERR_DIV_ZERO;
        else if (h_cls_i.min_m1) rec0.err = ERR_DIV_OVF;
        else                     rec0.is_div = 1'b1;
      end
      OP_MOD: begin
        if (h_cls_i.b_zero)       rec0.err = ERR_MOD_ZERO;
        else if (!h_cls_i.min_m1) rec0.is_mod = 1'b1;
      end
      OP_NEG: begin
        if (h_cls_i.a_min) rec0.err = ERR_NEG_OVF;
        else res0 = ~h_a_i + 1'b1;
      end
      OP_EQ:  res0 = DW'(h_a_i == h_b_i);
      OP_LT:  res0 = DW'($signed(h_a_i) < $signed(h_b_i));
      OP_AND: res0 = h_a_i & h_b_i;
      OP_OR:  res0 = h_a_i | h_b_i;
      OP_XOR: res0 = h_a_i ^ h_b_i;
      OP_NOT: res0 = ~h_a_i;
      OP_SHL: begin
        if (h_cls_i.shift_bad) rec0.err = ERR_SHIFT;
        else res0 = h_a_i << h_b_i[SW-1:0];
      end
      OP_SHR: begin
        if (h_cls_i.shift_bad) rec0.err = ERR_SHIFT;
        else res0 = DW'($signed(h_a_i) >>> h_b_i[SW-1:0]);
      end
      OP_BYTE: begin
        if (h_cls_i.byte_bad) rec0.err = ERR_BYTE;
        else res0 = h_a_i;
      end
      default: ;
    endcase
  end

  // finish multiply: range check against the signed limit
  assign lim     = rec_q[2].neg ? MinV : (MinV - 1'b1);
  assign mul_ovf = (prod_q[2*DW-1:DW] != '0) || (prod_q[DW-1:0] > lim);
  assign mul_res = rec_q[2].neg ? (~prod_q[DW-1:0] + 1'b1) : prod_q[DW-1:0];

  // one restoring divide step per stage; multiply result joins at stage 3
  always_comb begin
    logic [DW:0] t;
    logic        ge;
    for (int k = 0; k < N; k++) begin
      rem_d[k] = '0;
      dvd_d[k] = '0;
      res_d[k] = '0;
      rec_d[k] = '0;
    end
    for (int k = 0; k < N - 1; k++) begin
      t  = {rem_q[k], dvd_q[k][DW-1]};
      ge = (t >= {1'b0, dvs_q[k]});
      rem_d[k+1] = ge ? DW'(t - {1'b0, dvs_q[k]}) : t[DW-1:0];
      dvd_d[k+1] = {dvd_q[k][DW-2:0], ge};
      res_d[k+1] = res_q[k];
      rec_d[k+1] = rec_q[k];
      if (k == 2 && rec_q[k].is_mul) begin
        if (mul_ovf) rec_d[k+1].err = ERR_MUL_OVF;
        else         res_d[k+1]     = mul_res;
      end
    end
  end

  // select final value from the last stage
  always_comb begin
    if (rec_q[N-1].is_div)
      fin = rec_q[N-1].neg ? (~dvd_q[N-1] + 1'b1) : dvd_q[N-1];
    else if (rec_q[N-1].is_mod)
      fin = rec_q[N-1].a_neg ? (~rem_q[N-1] + 1'b1) : rem_q[N-1];
    else
      fin = res_q[N-1];
    if (rec_q[N-1].err != ERR_NONE) fin = '0;
  end

  // valid bits of the pipeline and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) vld_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= h_valid_i;
      for (int k = 1; k < N; k++) vld_q[k] <= vld_q[k-1];
      out_valid_q <= vld_q[N-1];
    end
  end

  // payload of the pipeline
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0] <= '0;
      dvd_q[0] <= mag_a;
      dvs_q[0] <= mag_b;
      res_q[0] <= res0;
      rec_q[0] <= rec0;
      for (int k = 1; k < N; k++) begin
        rem_q[k] <= rem_d[k];
        dvd_q[k] <= dvd_d[k];
        dvs_q[k] <= dvs_q[k-1];
        res_q[k] <= res_d[k];
        rec_q[k] <= rec_d[k];
      end
      pll_q  <= (2*L)'(dvd_q[0][L-1:0]) * (2*L)'(dvs_q[0][L-1:0]);
      plh_q  <= (L+H)'(dvd_q[0][L-1:0]) * (L+H)'(dvs_q[0][DW-1:L]);
      phl_q  <= (L+H)'(dvd_q[0][DW-1:L]) * (L+H)'(dvs_q[0][L-1:0]);
      phh_q  <= (2*H)'(dvd_q[0][DW-1:L]) * (2*H)'(dvs_q[0][DW-1:L]);
      prod_q <= (2*DW)'(pll_q) + ((2*DW)'(plh_q) << L) + ((2*DW)'(phl_q) << L)
              + ((2*DW)'(phh_q) << (2*L));
      out_res_q <= 64'($signed(fin));
      out_err_q <= rec_q[N-1].err;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.result     = out_res_q;
  assign rsp.error_code = out_err_q;

  `CIA_ASSERT_NOW(a_err_zero, out_valid_q && (out_err_q != ERR_NONE), out_res_q == 64'd0,
    "result not zero on error")
  `CIA_ASSERT_NOW(a_err_range, out_valid_q, out_err_q <= ERR_MAX, "error code out of range")
  `CIA_ASSERT_NEXT(a_hold_tail, !adv && vld_q[N-1], vld_q[N-1] && $stable(res_q[N-1]),
    "last stage moved while stalled")

endmodule

### sv/checked_integer_alu.sv
// channel | dir | payload                          | transfer
// req_i   | in  | cmd, operand_a, operand_b        | valid & ready
// rsp_o   | out | result, error_code               | valid & ready
//
// A request passes a two-entry queue stage, then a pipeline of DATA_WIDTH + 1
// stages set by the radix-2 divider, then the output register. One item is
// accepted per cycle unless the output stalls; the multiplier runs as three
// stages alongside. Reset clears the queue and pipeline valid bits; no clearing
// pass is needed. A stalled output freezes the whole back pipeline; the queue
// then fills and drops ready after at most two more items.
module checked_integer_alu import cia_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cia_req_if.sink  req_i,
  cia_rsp_if.source rsp_o
);

  localparam int unsigned QW = 4 + CLS_W + 2 * DATA_WIDTH;

  logic                  push, full, pop, h_valid;
  logic [3:0]            f_cmd, h_cmd;
  cls_t                  f_cls, h_cls;
  logic [DATA_WIDTH-1:0] f_a, f_b, h_a, h_b;
  logic [QW-1:0]         wdata, rdata;

  cia_front #(.DW(DATA_WIDTH)) u_front (
    .req    (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (f_cmd),
    .cls_o  (f_cls),
    .a_o    (f_a),
    .b_o    (f_b)
  );

  assign wdata = {f_cmd, f_cls, f_a, f_b};
  assign {h_cmd, h_cls, h_a, h_b} = rdata;

  cia_fifo #(.W(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (h_valid),
    .rdata_o (rdata)
  );

  cia_back #(.DW(DATA_WIDTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .h_valid_i (h_valid),
    .h_cmd_i   (h_cmd),
    .h_cls_i   (h_cls),
    .h_a_i     (h_a),
    .h_b_i     (h_b),
    .pop_o     (pop),
    .rsp       (rsp_o)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cia_pkg::*;

  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned LATENCY    = DATA_WIDTH + 3;
  localparam int unsigned HOLD_LEN   = 300;

  typedef struct {
    logic [3:0]  cmd;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } alu_op_t;

  typedef struct {
    logic [63:0] result;
    logic [3:0]  error_code;
  } alu_res_t;

  logic clk_i;
  logic rst_ni;

  cia_req_if req_if ();
  cia_rsp_if rsp_if ();

  checked_integer_alu #(.DATA_WIDTH(DATA_WIDTH)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  alu_op_t  pending_ops[$];
  alu_res_t expected_results[$];
  int       fail_cnt = 0;
  int       ops_sent = 0;
  int       results_seen = 0;
  int       trap_results = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       hold_cnt = 0;
  bit       hold_done = 0;
  bit       req_taken = 0;

  localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_V = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ONES  = '1;

  // Compute the value and trap code of one operation
  function automatic alu_res_t alu_predict(alu_op_t op);
    alu_res_t         r;
    logic signed [63:0] a, b;
    logic [63:0]      sum;
    logic [127:0]     prod;
    a = op.operand_a;
    b = op.operand_b;
    r.result = '0;
    r.error_code = ERR_NONE;
    case (op.cmd)
      OP_ADD: begin
        sum = a + b;
        if (a[63] == b[63] && sum[63] != a[63]) r.error_code = ERR_ADD_OVF;
        else r.result = sum;
      end
      OP_SUB: begin
        sum = a - b;
        if (a[63] != b[63] && sum[63] != a[63]) r.error_code = ERR_SUB_OVF;
        else r.result = sum;
      end
      OP_MUL: begin
        prod = {{64{a[63]}}, a} * {{64{b[63]}}, b};
        if (prod[127:63] != '0 && prod[127:63] != '1) r.error_code = ERR_MUL_OVF;
        else r.result = prod[63:0];
      end
      OP_DIV: begin
        if (b == 0) r.error_code = ERR_DIV_ZERO;
        else if (a == MIN_V && b == ONES) r.error_code = ERR_DIV_OVF;
        else r.result = a / b;
      end
      OP_MOD: begin
        if (b == 0) r.error_code = ERR_MOD_ZERO;
        else if (a == MIN_V && b == ONES) r.result = '0;
        else r.result = a % b;
      end
      OP_NEG: begin
        if (a == MIN_V) r.error_code = ERR_NEG_OVF;
        else r.result = -a;
      end
      OP_EQ:  r.result = (a == b) ? 64'd1 : 64'd0;
      OP_LT:  r.result = (a < b) ? 64'd1 : 64'd0;
      OP_AND: r.result = a & b;
      OP_OR:  r.result = a | b;
      OP_XOR: r.result = a ^ b;
      OP_NOT: r.result = ~a;
      OP_SHL: begin
        if (b < 0 || b > DATA_WIDTH - 1) r.error_code = ERR_SHIFT;
        else r.result = a << b[5:0];
      end
      OP_SHR: begin
        if (b < 0 || b > DATA_WIDTH - 1) r.error_code = ERR_SHIFT;
        else r.result = a >>> b[5:0];
      end
      OP_BYTE: begin
        if (a < 0 || a > BYTE_MAX) r.error_code = ERR_BYTE;
        else r.result = a;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Favor corner values, keep a share fully random
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN_V;
      1: return MAX_V;
      2: return '0;
      3: return ONES;
      4: return 64'd1;
      5: return 64'($signed($urandom_range(0, 511)) - 256);
      6: return 64'd1 << $urandom_range(0, 63);
      7: return {{32{1'b0}}, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_op_t rand_op();
    alu_op_t op;
    op.cmd = ($urandom_range(0, 40) == 0) ? OP_NOP : 4'($urandom_range(0, 14));
    op.operand_a = pick_operand();
    op.operand_b = pick_operand();
    if ((op.cmd == OP_SHL || op.cmd == OP_SHR) && $urandom_range(0, 4) != 0)
      op.operand_b = 64'($urandom_range(0, 63));
    if (op.cmd == OP_BYTE && $urandom_range(0, 2) != 0)
      op.operand_a = 64'($signed($urandom_range(0, 320)) - 20);
    return op;
  endfunction

  function automatic void add_op(logic [3:0] c, logic [63:0] a, logic [63:0] b);
    alu_op_t op;
    op.cmd = c;
    op.operand_a = a;
    op.operand_b = b;
    pending_ops.push_back(op);
  endfunction

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd = '0;
    req_if.operand_a = '0;
    req_if.operand_b = '0;
    rsp_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Drive request transfers from the pending queue
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      // hold the offered item
    end else if (send_gap > 0) begin
      send_gap--;
      req_if.valid <= 1'b0;
    end else if (pending_ops.size() > 0) begin
      if (pending_ops.size() > 150 && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 9);
        req_if.valid <= 1'b0;
      end else begin
        req_if.valid     <= 1'b1;
        req_if.cmd       <= pending_ops[0].cmd;
        req_if.operand_a <= pending_ops[0].operand_a;
        req_if.operand_b <= pending_ops[0].operand_b;
        void'(pending_ops.pop_front());
      end
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Drive response ready, with one long hold-off to fill the pipeline
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && ops_sent >= 300) begin
      hold_done = 1;
      hold_cnt = HOLD_LEN;
      rsp_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      rsp_if.ready <= 1'b0;
    end else if (pending_ops.size() > 150 && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 9);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Check response transfers, then record accepted requests
  always @(posedge clk_i) begin
    alu_op_t  op;
    alu_res_t exp_r;
    req_taken = 0;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result: expected none, actual %h err %0d", $realtime,
                   rsp_if.result, rsp_if.error_code);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.error_code != ERR_NONE) trap_results++;
          if (rsp_if.result !== exp_r.result) begin
            fail_cnt++;
            $display("%0t: result mismatch: expected %h, actual %h", $realtime,
                     exp_r.result, rsp_if.result);
          end
          if (rsp_if.error_code !== exp_r.error_code) begin
            fail_cnt++;
            $display("%0t: error_code mismatch: expected %0d, actual %0d", $realtime,
                     exp_r.error_code, rsp_if.error_code);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        req_taken = 1;
        ops_sent++;
        op.cmd = req_if.cmd;
        op.operand_a = req_if.operand_a;
        op.operand_b = req_if.operand_b;
        expected_results.push_back(alu_predict(op));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    add_op(OP_ADD, MAX_V, 64'd1);
    add_op(OP_ADD, MIN_V, ONES);
    add_op(OP_ADD, MAX_V, MIN_V);
    add_op(OP_SUB, MIN_V, 64'd1);
    add_op(OP_SUB, MAX_V, ONES);
    add_op(OP_MUL, MIN_V, ONES);
    add_op(OP_MUL, MIN_V, 64'd1);
    add_op(OP_MUL, 64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
    add_op(OP_MUL, ONES, ONES);
    add_op(OP_DIV, 64'd7, 64'd0);
    add_op(OP_DIV, MIN_V, ONES);
    add_op(OP_DIV, -64'sd7, 64'd2);
    add_op(OP_MOD, 64'd5, 64'd0);
    add_op(OP_MOD, MIN_V, ONES);
    add_op(OP_MOD, -64'sd7, 64'd2);
    add_op(OP_NEG, MIN_V, 64'd0);
    add_op(OP_NEG, MAX_V, ONES);
    add_op(OP_EQ, MIN_V, MIN_V);
    add_op(OP_LT, MIN_V, MAX_V);
    add_op(OP_AND, ONES, MIN_V);
    add_op(OP_OR, MAX_V, MIN_V);
    add_op(OP_XOR, ONES, MAX_V);
    add_op(OP_NOT, MIN_V, ONES);
    add_op(OP_SHL, ONES, 64'd63);
    add_op(OP_SHL, 64'd1, 64'd64);
    add_op(OP_SHR, MIN_V, 64'd63);
    add_op(OP_SHR, MIN_V, ONES);
    add_op(OP_BYTE, 64'd255, 64'd0);
    add_op(OP_BYTE, 64'd256, 64'd0);
    add_op(OP_BYTE, ONES, 64'd0);
    add_op(OP_NOP, ONES, ONES);
    repeat (1400) pending_ops.push_back(rand_op());

    wait (rst_ni);
    wait (pending_ops.size() == 0 && !req_if.valid && expected_results.size() == 0);
    repeat (LATENCY + 20) @(posedge clk_i);

    $display("Ran %0d operations over all opcodes and corner operands, %0d results checked,",
             ops_sent, results_seen);
    $display("%0d of them traps, with random stalls and one long output hold-off.",
             trap_results);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Overall time limit
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
